### src/scwh_pkg.sv
// ----------------------------------------------------------------------------
// scwh_pkg - shared types and constants
// Item formats, command codes and default sizes for the column weight
// histogram.
// ----------------------------------------------------------------------------
package scwh_pkg;

    localparam int MAX_COLUMNS_DEF = 65536;
    localparam int WEIGHT_BITS_DEF = 8;

    localparam int INDEX_W      = 16;
    localparam int COUNT_W      = 17;
    localparam int OUT_WEIGHT_W = 8;
    localparam int TOTAL_W      = 48;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(65536);

    typedef enum logic [1:0] {
        CMD_ADD       = 2'd0,
        CMD_READ      = 2'd1,
        CMD_SUMMARIZE = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_command;

    typedef struct packed {
        t_command           command;
        logic [INDEX_W-1:0] column_index;
    } t_in_item;

    typedef struct packed {
        logic [OUT_WEIGHT_W-1:0] column_weight;
        logic [COUNT_W-1:0]      nonempty_columns;
        logic [TOTAL_W-1:0]      total_weight;
    } t_out_item;

endpackage

### src/sparse_column_weight_histogram.sv
// ----------------------------------------------------------------------------
// sparse_column_weight_histogram - saturating per-column weight counter
// Counts nonzero entries per sparse-matrix column in one memory, with a
// saturating total, summarize, read and clear commands.
// ----------------------------------------------------------------------------
// Add and read items are taken one per cycle while running, unless a read
// waits on a held output register: each reads its column from the weight
// memory into stage B, where the weight is bumped and written back (the last
// write is forwarded to cover the memory's read latency) or handed to the
// output register. Adds beyond the active column count are dropped on entry.
// Summarize waits for the pipeline to drain, then scans the memory at one
// column a cycle. Clear, and likewise reset, sweeps all MAX_COLUMNS entries
// (65536 by default) at one entry a cycle, during which no item is accepted;
// configuration writes are taken throughout.
module sparse_column_weight_histogram #(
    parameter int MAX_COLUMNS = scwh_pkg::MAX_COLUMNS_DEF,
    parameter int WEIGHT_BITS = scwh_pkg::WEIGHT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [scwh_pkg::COUNT_W-1:0]   i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  scwh_pkg::t_in_item             i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output scwh_pkg::t_out_item            o_out
);

    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int ACT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int WIDE_W = (ACT_W > scwh_pkg::COUNT_W) ? ACT_W : scwh_pkg::COUNT_W;

    localparam logic [WEIGHT_BITS-1:0]       WEIGHT_MAX = '1;
    localparam logic [scwh_pkg::TOTAL_W-1:0] TOTAL_MAX  = '1;
    localparam logic [ADDR_W-1:0]            LAST_ADDR  = ADDR_W'(MAX_COLUMNS - 1);
    localparam logic [WIDE_W-1:0]            MAX_WIDE   = WIDE_W'(MAX_COLUMNS);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SUM
    } t_state;

    t_state                          r_state;
    logic [scwh_pkg::COUNT_W-1:0]    r_count;
    logic [scwh_pkg::TOTAL_W-1:0]    r_total;
    logic [ADDR_W-1:0]               r_clr_addr;

    // stage B: item whose weight is coming out of the memory
    logic                            r_b_valid;
    logic                            r_b_is_add;
    logic                            r_b_inrange;
    logic [ADDR_W-1:0]               r_b_addr;

    // last write, for forwarding
    logic                            r_last_valid;
    logic [ADDR_W-1:0]               r_last_addr;
    logic [WEIGHT_BITS-1:0]          r_last_data;

    // summarize scan
    logic [ACT_W-1:0]                r_scan;
    logic                            r_chk_valid;
    logic [ACT_W-1:0]                r_nonempty;

    logic                            r_out_valid;
    scwh_pkg::t_out_item             r_out;

    logic [WIDE_W-1:0]               active_wide;
    logic [ACT_W-1:0]                active;
    logic                            in_range;
    logic                            is_ctrl;
    logic                            in_acc;
    logic                            out_free;
    logic                            b_adv;
    logic [WEIGHT_BITS-1:0]          old_weight;
    logic [WEIGHT_BITS-1:0]          new_weight;
    logic                            scan_more;
    logic                            sum_done;

    logic                            ram_wr_en;
    logic [ADDR_W-1:0]               ram_wr_addr;
    logic [WEIGHT_BITS-1:0]          ram_wr_data;
    logic                            ram_rd_en;
    logic [ADDR_W-1:0]               ram_rd_addr;
    logic [WEIGHT_BITS-1:0]          ram_rd_data;

    assign active_wide = (WIDE_W'(r_count) > MAX_WIDE) ? MAX_WIDE : WIDE_W'(r_count);
    assign active      = ACT_W'(active_wide);
    assign in_range    = WIDE_W'(i_in.column_index) < active_wide;
    assign is_ctrl     = (i_in.command == scwh_pkg::CMD_SUMMARIZE)
                      || (i_in.command == scwh_pkg::CMD_CLEAR);

    assign out_free = !r_out_valid || i_out_ready;
    assign b_adv    = r_b_valid && (r_b_is_add || out_free);

    // summarize and clear only enter an empty pipeline
    assign o_in_ready = (r_state == ST_RUN) && (!r_b_valid || b_adv)
                     && !(is_ctrl && r_b_valid);
    assign in_acc     = i_in_valid && o_in_ready;

    assign old_weight = (r_last_valid && (r_last_addr == r_b_addr)) ? r_last_data
                                                                    : ram_rd_data;
    assign new_weight = (old_weight == WEIGHT_MAX) ? old_weight
                                                   : old_weight + WEIGHT_BITS'(1);

    assign scan_more = r_scan < active;
    assign sum_done  = !scan_more && !r_chk_valid && out_free;

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_b_addr;
        ram_wr_data = new_weight;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ADDR_W'(i_in.column_index);
        unique case (r_state)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
            end
            ST_RUN: begin
                ram_wr_en = b_adv && r_b_is_add;
                ram_rd_en = in_acc;
            end
            ST_SUM: begin
                ram_rd_en   = scan_more;
                ram_rd_addr = r_scan[ADDR_W-1:0];
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    scwh_weight_ram #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (WEIGHT_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_count      <= scwh_pkg::COUNT_RESET;
            r_total      <= '0;
            r_clr_addr   <= '0;
            r_b_valid    <= 1'b0;
            r_last_valid <= 1'b0;
            r_chk_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_last_valid <= 1'b0;
                    r_clr_addr   <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (b_adv) begin
                        r_b_valid <= 1'b0;
                        if (r_b_is_add) begin
                            r_last_valid <= 1'b1;
                            r_last_addr  <= r_b_addr;
                            r_last_data  <= new_weight;
                            if (r_total != TOTAL_MAX) begin
                                r_total <= r_total + scwh_pkg::TOTAL_W'(1);
                            end
                        end else begin
                            r_out_valid            <= 1'b1;
                            r_out.column_weight    <= r_b_inrange
                                ? scwh_pkg::OUT_WEIGHT_W'(old_weight) : '0;
                            r_out.nonempty_columns <= '0;
                            r_out.total_weight     <= '0;
                        end
                    end
                    if (in_acc) begin
                        unique case (i_in.command)
                            scwh_pkg::CMD_ADD: begin
                                // out-of-range adds leave no trace
                                r_b_valid   <= in_range;
                                r_b_is_add  <= 1'b1;
                                r_b_inrange <= in_range;
                                r_b_addr    <= ADDR_W'(i_in.column_index);
                            end
                            scwh_pkg::CMD_READ: begin
                                r_b_valid   <= 1'b1;
                                r_b_is_add  <= 1'b0;
                                r_b_inrange <= in_range;
                                r_b_addr    <= ADDR_W'(i_in.column_index);
                            end
                            scwh_pkg::CMD_SUMMARIZE: begin
                                r_state     <= ST_SUM;
                                r_scan      <= '0;
                                r_chk_valid <= 1'b0;
                                r_nonempty  <= '0;
                            end
                            scwh_pkg::CMD_CLEAR: begin
                                r_state    <= ST_CLEAR;
                                r_clr_addr <= '0;
                                r_total    <= '0;
                            end
                            default: begin
                                r_b_valid <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_SUM: begin
                    r_chk_valid <= scan_more;
                    if (scan_more) begin
                        r_scan <= r_scan + ACT_W'(1);
                    end
                    if (r_chk_valid && (ram_rd_data != '0)) begin
                        r_nonempty <= r_nonempty + ACT_W'(1);
                    end
                    if (sum_done) begin
                        r_state                <= ST_RUN;
                        r_out_valid            <= 1'b1;
                        r_out.column_weight    <= '0;
                        r_out.nonempty_columns <= scwh_pkg::COUNT_W'(r_nonempty);
                        r_out.total_weight     <= r_total;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### src/scwh_weight_ram.sv
// ----------------------------------------------------------------------------
// scwh_weight_ram - column weight store
// Simple dual-port memory: one write port, one read port with registered
// read data. Read data holds while the read is idle.
// ----------------------------------------------------------------------------
module scwh_weight_ram #(
    parameter int DEPTH = scwh_pkg::MAX_COLUMNS_DEF,
    parameter int WIDTH = scwh_pkg::WEIGHT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### tb/sv/scwh_checker.sv
// ----------------------------------------------------------------------------
// scwh_checker - result checker for the column weight histogram
// Watches the configuration port and both item channels, keeps its own
// column weights, total and column count, and compares every accepted
// result field by field with the oldest awaited report.
// ----------------------------------------------------------------------------
module scwh_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [scwh_pkg::COUNT_W-1:0] i_cfg_wr_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  scwh_pkg::t_in_item           i_in,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  scwh_pkg::t_out_item          i_out,
    output int                           o_mismatches,
    output int                           o_pending
);

    localparam int COLUMNS = scwh_pkg::MAX_COLUMNS_DEF;
    localparam int WB      = scwh_pkg::WEIGHT_BITS_DEF;

    localparam logic [WB-1:0]                WEIGHT_TOP = '1;
    localparam logic [scwh_pkg::TOTAL_W-1:0] TOTAL_TOP  = '1;

    logic [WB-1:0]                weight_store [COLUMNS];
    logic [scwh_pkg::TOTAL_W-1:0] entry_sum;
    logic [scwh_pkg::COUNT_W-1:0] column_limit;
    scwh_pkg::t_out_item          awaited_reports [$];
    int                           mismatch_tally = 0;

    function automatic int unsigned visible_columns();
        return (column_limit > COLUMNS) ? COLUMNS : column_limit;
    endfunction

    task automatic wipe_histogram();
        foreach (weight_store[j]) weight_store[j] = '0;
        entry_sum = '0;
    endtask

    task automatic await_report(input scwh_pkg::t_out_item report);
        awaited_reports = {awaited_reports, report};
    endtask

    task automatic tally_item(input scwh_pkg::t_in_item it);
        int unsigned         span;
        int unsigned         occupied;
        int unsigned         j;
        scwh_pkg::t_out_item report;
        span   = visible_columns();
        report = '0;
        case (it.command)
            scwh_pkg::CMD_ADD: begin
                // out-of-range adds leave no trace at all
                if (it.column_index < span) begin
                    if (weight_store[it.column_index] != WEIGHT_TOP)
                        weight_store[it.column_index] += WB'(1);
                    if (entry_sum != TOTAL_TOP)
                        entry_sum += scwh_pkg::TOTAL_W'(1);
                end
            end
            scwh_pkg::CMD_READ: begin
                if (it.column_index < span)
                    report.column_weight =
                        scwh_pkg::OUT_WEIGHT_W'(weight_store[it.column_index]);
                await_report(report);
            end
            scwh_pkg::CMD_SUMMARIZE: begin
                // columns above the count keep their weights but stay hidden
                occupied = 0;
                for (j = 0; j < span; j++)
                    if (weight_store[j] != '0) occupied++;
                report.nonempty_columns = scwh_pkg::COUNT_W'(occupied);
                report.total_weight     = entry_sum;
                await_report(report);
            end
            scwh_pkg::CMD_CLEAR: wipe_histogram();
        endcase
    endtask

    task automatic check_report(input scwh_pkg::t_out_item got);
        scwh_pkg::t_out_item want;
        if (awaited_reports.size() == 0) begin
            $error("result with none awaited: column_weight %0d, %s %0d, total_weight %0d",
                   got.column_weight, "nonempty_columns", got.nonempty_columns,
                   got.total_weight);
            mismatch_tally++;
            return;
        end
        want = awaited_reports.pop_front();
        if (got.column_weight !== want.column_weight) begin
            $error("column_weight: expected %0d, got %0d", want.column_weight, got.column_weight);
            mismatch_tally++;
        end
        if (got.nonempty_columns !== want.nonempty_columns) begin
            $error("nonempty_columns: expected %0d, got %0d",
                   want.nonempty_columns, got.nonempty_columns);
            mismatch_tally++;
        end
        if (got.total_weight !== want.total_weight) begin
            $error("total_weight: expected %0d, got %0d", want.total_weight, got.total_weight);
            mismatch_tally++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_histogram();
            column_limit = scwh_pkg::COUNT_RESET;
            awaited_reports.delete();
        end else begin
            // a result never leaves on the edge its own item enters
            if (i_out_valid && i_out_ready) check_report(i_out);
            // an item taken on a write edge still sees the old count
            if (i_in_valid && i_in_ready) tally_item(i_in);
            if (i_cfg_wr_en) column_limit = i_cfg_wr_data;
        end
        o_mismatches <= mismatch_tally;
        o_pending    <= awaited_reports.size();
    end

endmodule

### tb/sv/tb_sparse_column_weight_histogram.sv
// ----------------------------------------------------------------------------
// tb_sparse_column_weight_histogram - testbench top for the histogram
// Drives directed and random add, read, summarize and clear items over a
// series of column counts and idling patterns, including a long output
// hold-off; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_sparse_column_weight_histogram;

    localparam int QUIET_LIMIT   = 262144;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 35;
    localparam int BURST_ITEMS   = 280;
    localparam int HOLD_PHASE    = 4;
    localparam int BURST_PHASE   = 5;

    localparam logic [scwh_pkg::COUNT_W-1:0] COUNT_ALL_ONES = '1;

    logic                         clk;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [scwh_pkg::COUNT_W-1:0] cfg_wr_data = '0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    scwh_pkg::t_in_item           in_item     = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    scwh_pkg::t_out_item          out_item;
    int                           mismatches;
    int                           pending;
    int                           snd_idle_pct  = 0;
    int                           rcv_stall_pct = 0;
    bit                           hold_req      = 1'b0;
    int                           quiet_cycles  = 0;

    sparse_column_weight_histogram uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in          (in_item),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out         (out_item)
    );

    scwh_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in          (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out         (out_item),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly in range, a share just past the count, the rest anywhere
    function automatic logic [scwh_pkg::INDEX_W-1:0] pick_column(int unsigned span);
        int unsigned roll;
        int unsigned beyond;
        roll   = $urandom_range(99);
        beyond = span + $urandom_range(7);
        if (span == 0 || roll >= 85 || (roll >= 70 && beyond >= (1 << scwh_pkg::INDEX_W)))
            return scwh_pkg::INDEX_W'($urandom);
        if (roll >= 70)
            return scwh_pkg::INDEX_W'(beyond);
        if (span > 64 && roll < 40)
            return scwh_pkg::INDEX_W'($urandom_range(63));
        return scwh_pkg::INDEX_W'($urandom_range(span - 1));
    endfunction

    task automatic offer(input scwh_pkg::t_command cmd,
                         input logic [scwh_pkg::INDEX_W-1:0] col);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{command: cmd, column_index: col};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_column_count(input logic [scwh_pkg::COUNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // output side: random stalls, or one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sparse_column_weight_histogram: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [scwh_pkg::COUNT_W-1:0] counts [PHASES];
        logic [scwh_pkg::INDEX_W-1:0] hot;
        int unsigned                  span;
        int unsigned                  roll;
        int                           clears_left;
        int                           p;
        scwh_pkg::t_command           cmd;

        counts = '{17'd1, 17'd65536, 17'd37, COUNT_ALL_ONES, 17'd4,
                   17'd2, 17'd0, 17'd65535, 17'd0, 17'd0};
        counts[6]   = scwh_pkg::COUNT_W'($urandom_range(700, 5));
        counts[9]   = scwh_pkg::COUNT_W'($urandom_range(64, 1));
        clears_left = 3;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // full column range straight after reset
        offer(scwh_pkg::CMD_READ, 16'd0);
        offer(scwh_pkg::CMD_ADD, 16'd0);
        offer(scwh_pkg::CMD_ADD, 16'hFFFF);
        offer(scwh_pkg::CMD_ADD, 16'hFFFF);
        offer(scwh_pkg::CMD_ADD, 16'h5A5A);
        offer(scwh_pkg::CMD_READ, 16'hFFFF);
        offer(scwh_pkg::CMD_READ, 16'hA5A5);
        offer(scwh_pkg::CMD_READ, 16'd0);
        offer(scwh_pkg::CMD_SUMMARIZE, 16'hFFFF);
        offer(scwh_pkg::CMD_CLEAR, 16'h1234);
        offer(scwh_pkg::CMD_READ, 16'hFFFF);
        offer(scwh_pkg::CMD_ADD, 16'd7);
        offer(scwh_pkg::CMD_READ, 16'd7);
        drain();

        // small count: adds and reads at and past the edge
        set_column_count(17'd3);
        offer(scwh_pkg::CMD_ADD, 16'd2);
        offer(scwh_pkg::CMD_ADD, 16'd3);
        offer(scwh_pkg::CMD_ADD, 16'hFFFF);
        offer(scwh_pkg::CMD_READ, 16'd3);
        offer(scwh_pkg::CMD_READ, 16'd2);
        offer(scwh_pkg::CMD_SUMMARIZE, 16'd0);
        drain();

        // zero count: nothing is active
        set_column_count(17'd0);
        offer(scwh_pkg::CMD_ADD, 16'd0);
        offer(scwh_pkg::CMD_READ, 16'd0);
        offer(scwh_pkg::CMD_SUMMARIZE, 16'd0);
        drain();

        for (p = 0; p < PHASES; p++) begin
            set_column_count(counts[p]);
            span = (counts[p] > scwh_pkg::MAX_COLUMNS_DEF) ? scwh_pkg::MAX_COLUMNS_DEF
                                                            : counts[p];
            case (p % 4)
                0: begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 0;
                end
                1: begin
                    snd_idle_pct  = 54;
                    rcv_stall_pct = 0;
                end
                2: begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 54;
                end
                default: begin
                    snd_idle_pct  = 23;
                    rcv_stall_pct = 23;
                end
            endcase
            if (p == HOLD_PHASE) hold_req = 1'b1;

            // hammer one column with a long burst of adds and occasional reads
            if (p == BURST_PHASE) begin
                hot = scwh_pkg::INDEX_W'($urandom_range(span - 1));
                repeat (BURST_ITEMS) begin
                    if ($urandom_range(9) == 0)
                        cmd = scwh_pkg::CMD_READ;
                    else
                        cmd = scwh_pkg::CMD_ADD;
                    offer(cmd, hot);
                end
            end

            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(999);
                if (roll < 8 && clears_left > 0) begin
                    clears_left--;
                    cmd = scwh_pkg::CMD_CLEAR;
                end else if (roll < 550) begin
                    cmd = scwh_pkg::CMD_ADD;
                end else if (roll < 850 || span > 1024) begin
                    // a summarize scans every active column, so keep it to small counts
                    cmd = scwh_pkg::CMD_READ;
                end else begin
                    cmd = scwh_pkg::CMD_SUMMARIZE;
                end
                offer(cmd, pick_column(span));
            end

            // end on a result so the drain also waits out a running clear
            if (span <= 1024 || counts[p] == COUNT_ALL_ONES)
                cmd = scwh_pkg::CMD_SUMMARIZE;
            else
                cmd = scwh_pkg::CMD_READ;
            offer(cmd, pick_column(span));
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("tb_sparse_column_weight_histogram: done, clean");
        else
            $display("tb_sparse_column_weight_histogram: done, errors");
        $finish;
    end

endmodule

### filelist.f
src/scwh_pkg.sv
src/scwh_weight_ram.sv
src/sparse_column_weight_histogram.sv
tb/sv/scwh_checker.sv
tb/sv/tb_sparse_column_weight_histogram.sv
